@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the balancer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define CHK_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("balancer check failed");

// Next-cycle implication, disabled while reset is high
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("balancer check failed");

`endif

@@ hdl/tqlb_pkg.sv @@
// ----------------------------------------------------------------------------
// tqlb_pkg
// Widths, codes, reset table and reward function of the Q-learning balancer.
// ----------------------------------------------------------------------------
package tqlb_pkg;

  // Field widths
  localparam int TILT_W    = 18;
  localparam int FRAC_W    = 16;
  localparam int ACT_W     = 2;
  localparam int CLS_W     = 2;
  localparam int REW_W     = 18;
  localparam int CFG_IDX_W = 3;

  // Table geometry and arithmetic widths
  localparam int NUM_ACTIONS = 3;
  localparam int NUM_STATES  = 3;
  localparam int Q_COLS      = 3;
  localparam int Q_ENTRIES   = NUM_STATES * Q_COLS;
  localparam int ADDR_W      = $clog2(Q_ENTRIES);
  localparam int Q_WIDTH     = 32;
  localparam int DIFF_W      = Q_WIDTH + 3;
  localparam int PROD_W      = DIFF_W + FRAC_W + 1;
  localparam int REW_SHIFT   = 8;

  localparam logic signed [PROD_W-1:0] ROUND_HALF =
    {{(PROD_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};
  localparam logic signed [Q_WIDTH-1:0] Q_MAX = {1'b0, {(Q_WIDTH-1){1'b1}}};
  localparam logic signed [Q_WIDTH-1:0] Q_MIN = {1'b1, {(Q_WIDTH-1){1'b0}}};

  // Tilt classes
  localparam logic [CLS_W-1:0] CLS_BAL  = 2'd0;
  localparam logic [CLS_W-1:0] CLS_LOW  = 2'd1;
  localparam logic [CLS_W-1:0] CLS_HIGH = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TRAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LRATE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISC    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE = 3'd4;

  // Configuration reset values
  localparam logic [FRAC_W-1:0] LRATE_RESET   = 16'd328;
  localparam logic [FRAC_W-1:0] DISC_RESET    = 16'd66;
  localparam logic [FRAC_W-1:0] BAND_RESET    = 16'd26;
  localparam logic [FRAC_W-1:0] EXPLORE_RESET = 16'd0;

  // Rewards
  localparam logic signed [REW_W-1:0] REW_GOAL    = REW_W'(100000);
  localparam logic signed [REW_W-1:0] REW_FALL    = REW_W'(-100000);
  localparam logic signed [REW_W-1:0] REW_STUCK   = REW_W'(-10);
  localparam logic signed [REW_W-1:0] REW_HOLD    = REW_W'(1);
  localparam logic signed [REW_W-1:0] REW_NEUTRAL = REW_W'(0);

  // Trained table, Q.8, row = state, column = action
  localparam logic signed [Q_WIDTH-1:0] Q_RESET [Q_ENTRIES] = '{
    Q_WIDTH'(-2306988), Q_WIDTH'(-3405164), Q_WIDTH'(-2399295),
    Q_WIDTH'(-680546),  Q_WIDTH'(11297),    Q_WIDTH'(3071339),
    Q_WIDTH'(1848),     Q_WIDTH'(1362407),  Q_WIDTH'(238372)
  };

  // Sequencer states
  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_CLASS,
    FSM_SCAN,
    FSM_GMUL,
    FSM_DIFF,
    FSM_SMUL,
    FSM_WRITE,
    FSM_OUT
  } fsm_t;

  // Reward over (current, previous) class
  function automatic logic signed [REW_W-1:0] reward_of(
    input logic [CLS_W-1:0] cur,
    input logic [CLS_W-1:0] prev
  );
    logic signed [REW_W-1:0] r;
    if (cur == CLS_LOW && prev == CLS_LOW) begin
      r = REW_NEUTRAL;
    end else if (cur == CLS_HIGH && prev == CLS_HIGH) begin
      r = REW_STUCK;
    end else if (cur == CLS_BAL && prev != CLS_BAL) begin
      r = REW_GOAL;
    end else if (cur != CLS_BAL && prev == CLS_BAL) begin
      r = REW_FALL;
    end else if (cur == CLS_BAL && prev == CLS_BAL) begin
      r = REW_HOLD;
    end else begin
      r = REW_NEUTRAL;
    end
    return r;
  endfunction

endpackage

@@ hdl/tqlb_if.sv @@
// ----------------------------------------------------------------------------
// tqlb_if
// Valid/ready channels of the balancer: input beat, result beat, config write.
// ----------------------------------------------------------------------------

// One control period's measurement
interface tqlb_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [tqlb_pkg::TILT_W-1:0]  tilt;
  logic        [tqlb_pkg::FRAC_W-1:0]  random_fraction;
  logic        [tqlb_pkg::ACT_W-1:0]   random_action;

  modport source (output valid, tilt, random_fraction, random_action, input ready);
  modport sink   (input valid, tilt, random_fraction, random_action, output ready);
endinterface

// One result per period
interface tqlb_out_if;
  logic                               valid;
  logic                               ready;
  logic        [tqlb_pkg::ACT_W-1:0]  action;
  logic        [tqlb_pkg::CLS_W-1:0]  cur_state;
  logic signed [tqlb_pkg::REW_W-1:0]  reward;
  logic                               updated;

  modport source (output valid, action, cur_state, reward, updated, input ready);
  modport sink   (input valid, action, cur_state, reward, updated, output ready);
endinterface

// Register write channel
interface tqlb_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [tqlb_pkg::CFG_IDX_W-1:0]      index;
  logic [tqlb_pkg::FRAC_W-1:0]         data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/tabular_q_learning_balancer.sv @@
// ----------------------------------------------------------------------------
// tabular_q_learning_balancer
// Tilt classifier with a 3x3 Q table, TD update and epsilon-greedy choice.
// sample: one beat per control period (tilt, random fraction, random action).
// result: one beat per sample (action, class, reward, updated flag).
// cfg: register writes, always ready; write only while the block is idle.
// A small sequencer drives one shared multiplier and one table read port.
// Steps per item: CLASS, SCAN of the row, then with an update GMUL, DIFF,
// SMUL and WRITE (and a second SCAN when the updated row is the current one),
// then OUT. The row scan reads one action per step; the two dependent
// multiplies of the update share the single multiplier. sample.ready is high
// only in idle, so one item is in work at a time; OUT returns to idle.
// The result sits in an output register: if result.ready is low the block
// finishes the next item and waits in its last step until the register frees.
// Reset reloads the trained Q table and register defaults.
// ----------------------------------------------------------------------------
module tabular_q_learning_balancer (
  input  logic              clk,
  input  logic              rst,
  tqlb_in_if.sink           sample,
  tqlb_out_if.source        result,
  tqlb_cfg_if.sink          cfg
);

  // Sequencer
  tqlb_pkg::fsm_t state, state_next;

  // Configuration
  logic                          train_enable;
  logic [tqlb_pkg::FRAC_W-1:0]   learn_rate;
  logic [tqlb_pkg::FRAC_W-1:0]   discount;
  logic [tqlb_pkg::FRAC_W-1:0]   balance_band;
  logic [tqlb_pkg::FRAC_W-1:0]   explore_level;

  // Captured item
  logic signed [tqlb_pkg::TILT_W-1:0] item_tilt;
  logic        [tqlb_pkg::FRAC_W-1:0] item_rfrac;
  logic        [tqlb_pkg::ACT_W-1:0]  item_ract;

  // Learner state
  logic signed [tqlb_pkg::Q_WIDTH-1:0] q_table [tqlb_pkg::Q_ENTRIES];
  logic [tqlb_pkg::CLS_W-1:0]          prev_state;
  logic [tqlb_pkg::ACT_W-1:0]          last_action;
  logic                                have_prev;

  // Working registers
  logic [tqlb_pkg::CLS_W-1:0]          cur_cls;
  logic                                upd_pend;
  logic [tqlb_pkg::ACT_W-1:0]          scan_j;
  logic [tqlb_pkg::ACT_W-1:0]          best_act;
  logic signed [tqlb_pkg::Q_WIDTH-1:0] best_val;
  logic signed [tqlb_pkg::Q_WIDTH-1:0] q_old;
  logic signed [tqlb_pkg::DIFF_W-1:0]  diff;
  logic signed [tqlb_pkg::PROD_W-1:0]  prod;
  logic signed [tqlb_pkg::REW_W-1:0]   rew_val;
  logic                                upd_flag;

  // Output register
  logic                                out_valid;
  logic [tqlb_pkg::ACT_W-1:0]          out_action;
  logic [tqlb_pkg::CLS_W-1:0]          out_cls;
  logic signed [tqlb_pkg::REW_W-1:0]   out_reward;
  logic                                out_updated;

  // Sequencer outputs
  logic                                in_ready;
  logic                                use_lr;
  logic [tqlb_pkg::CLS_W-1:0]          rd_row;
  logic [tqlb_pkg::ACT_W-1:0]          rd_col;

  // Datapath nets
  logic [tqlb_pkg::ADDR_W-1:0]         rd_addr;
  logic signed [tqlb_pkg::Q_WIDTH-1:0] q_rd;
  logic signed [tqlb_pkg::DIFF_W-1:0]  mul_a;
  logic signed [tqlb_pkg::FRAC_W:0]    mul_b;
  logic signed [tqlb_pkg::PROD_W-1:0]  prod_next;
  logic signed [tqlb_pkg::PROD_W-1:0]  prod_rnd;
  logic signed [tqlb_pkg::PROD_W-1:0]  prod_sh;
  logic signed [tqlb_pkg::DIFF_W-1:0]  frac_term;
  logic signed [tqlb_pkg::REW_W-1:0]   rew_now;
  logic signed [tqlb_pkg::DIFF_W-1:0]  diff_next;
  logic signed [tqlb_pkg::DIFF_W-1:0]  q_sum;
  logic                                q_ovf;
  logic signed [tqlb_pkg::Q_WIDTH-1:0] q_new;
  logic signed [tqlb_pkg::TILT_W:0]    tilt_ext;
  logic        [tqlb_pkg::TILT_W:0]    tilt_mag;
  logic [tqlb_pkg::CLS_W-1:0]          cls_next;
  logic                                explore;
  logic [tqlb_pkg::ACT_W-1:0]          rand_act;
  logic [tqlb_pkg::ACT_W-1:0]          act_pick;
  logic                                scan_last;
  logic                                slot_free;

  assign scan_last = (scan_j == tqlb_pkg::ACT_W'(tqlb_pkg::NUM_ACTIONS - 1));
  assign slot_free = !out_valid || result.ready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      tqlb_pkg::FSM_IDLE: begin
        if (sample.valid) state_next = tqlb_pkg::FSM_CLASS;
      end
      tqlb_pkg::FSM_CLASS: state_next = tqlb_pkg::FSM_SCAN;
      tqlb_pkg::FSM_SCAN: begin
        if (scan_last) state_next = upd_pend ? tqlb_pkg::FSM_GMUL : tqlb_pkg::FSM_OUT;
      end
      tqlb_pkg::FSM_GMUL:  state_next = tqlb_pkg::FSM_DIFF;
      tqlb_pkg::FSM_DIFF:  state_next = tqlb_pkg::FSM_SMUL;
      tqlb_pkg::FSM_SMUL:  state_next = tqlb_pkg::FSM_WRITE;
      tqlb_pkg::FSM_WRITE: begin
        // updated row is the current one: argmax must be taken again
        state_next = (prev_state == cur_cls) ? tqlb_pkg::FSM_SCAN : tqlb_pkg::FSM_OUT;
      end
      tqlb_pkg::FSM_OUT: begin
        if (slot_free) state_next = tqlb_pkg::FSM_IDLE;
      end
      default: state_next = tqlb_pkg::FSM_IDLE;
    endcase
  end

  // Sequencer outputs: read port address and multiplier operand select
  always_comb begin
    in_ready = 1'b0;
    use_lr   = 1'b0;
    rd_row   = cur_cls;
    rd_col   = scan_j;
    case (state)
      tqlb_pkg::FSM_IDLE: in_ready = 1'b1;
      tqlb_pkg::FSM_DIFF, tqlb_pkg::FSM_WRITE: begin
        rd_row = prev_state;
        rd_col = last_action;
      end
      tqlb_pkg::FSM_SMUL: use_lr = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= tqlb_pkg::FSM_IDLE;
    else     state <= state_next;
  end

  // Table read port
  assign rd_addr = tqlb_pkg::ADDR_W'(rd_row) * tqlb_pkg::ADDR_W'(tqlb_pkg::Q_COLS)
                 + tqlb_pkg::ADDR_W'(rd_col);
  assign q_rd    = q_table[rd_addr];

  // Shared multiplier: gamma * Qmax, then alpha * diff
  assign mul_a     = use_lr ? diff : tqlb_pkg::DIFF_W'(best_val);
  assign mul_b     = signed'({1'b0, (use_lr ? learn_rate : discount)});
  assign prod_next = mul_a * mul_b;

  // Round to nearest, ties toward plus infinity, drop the 16 fraction bits
  assign prod_rnd  = prod + tqlb_pkg::ROUND_HALF;
  assign prod_sh   = prod_rnd >>> tqlb_pkg::FRAC_W;
  assign frac_term = prod_sh[tqlb_pkg::DIFF_W-1:0];

  // TD error
  assign rew_now   = tqlb_pkg::reward_of(cur_cls, prev_state);
  assign diff_next = (tqlb_pkg::DIFF_W'(rew_now) <<< tqlb_pkg::REW_SHIFT)
                   + frac_term - tqlb_pkg::DIFF_W'(q_rd);

  // New Q value with saturation
  assign q_sum = tqlb_pkg::DIFF_W'(q_old) + frac_term;
  assign q_ovf = !(&q_sum[tqlb_pkg::DIFF_W-1:tqlb_pkg::Q_WIDTH-1])
              && (|q_sum[tqlb_pkg::DIFF_W-1:tqlb_pkg::Q_WIDTH-1]);
  assign q_new = q_ovf ? (q_sum[tqlb_pkg::DIFF_W-1] ? tqlb_pkg::Q_MIN : tqlb_pkg::Q_MAX)
                       : q_sum[tqlb_pkg::Q_WIDTH-1:0];

  // Tilt classification; zero tilt is balanced even with a zero band
  assign tilt_ext = {item_tilt[tqlb_pkg::TILT_W-1], item_tilt};
  assign tilt_mag = tilt_ext[tqlb_pkg::TILT_W] ? -tilt_ext : tilt_ext;
  always_comb begin
    if (tilt_mag < {{(tqlb_pkg::TILT_W + 1 - tqlb_pkg::FRAC_W){1'b0}}, balance_band}
        || item_tilt == '0) begin
      cls_next = tqlb_pkg::CLS_BAL;
    end else if (!item_tilt[tqlb_pkg::TILT_W-1]) begin
      cls_next = tqlb_pkg::CLS_HIGH;
    end else begin
      cls_next = tqlb_pkg::CLS_LOW;
    end
  end

  // Epsilon-greedy pick; out-of-range random action wraps
  assign explore  = item_rfrac < explore_level;
  assign rand_act = (item_ract >= tqlb_pkg::ACT_W'(tqlb_pkg::NUM_ACTIONS))
                  ? item_ract - tqlb_pkg::ACT_W'(tqlb_pkg::NUM_ACTIONS) : item_ract;
  assign act_pick = explore ? rand_act : best_act;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      train_enable  <= 1'b0;
      learn_rate    <= tqlb_pkg::LRATE_RESET;
      discount      <= tqlb_pkg::DISC_RESET;
      balance_band  <= tqlb_pkg::BAND_RESET;
      explore_level <= tqlb_pkg::EXPLORE_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        tqlb_pkg::CFG_TRAIN:   train_enable  <= cfg.data[0];
        tqlb_pkg::CFG_LRATE:   learn_rate    <= cfg.data;
        tqlb_pkg::CFG_DISC:    discount      <= cfg.data;
        tqlb_pkg::CFG_BAND:    balance_band  <= cfg.data;
        tqlb_pkg::CFG_EXPLORE: explore_level <= cfg.data;
        default: ;
      endcase
    end
  end

  // Q table: reset to the trained values, one write in the write step
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tqlb_pkg::Q_ENTRIES; i++) begin
        q_table[i] <= tqlb_pkg::Q_RESET[i];
      end
    end else if (state == tqlb_pkg::FSM_WRITE) begin
      q_table[rd_addr] <= q_new;
    end
  end

  // Learner control state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_state  <= tqlb_pkg::CLS_BAL;
      last_action <= '0;
      have_prev   <= 1'b0;
      upd_pend    <= 1'b0;
    end else begin
      if (state == tqlb_pkg::FSM_CLASS) upd_pend <= train_enable && have_prev;
      if (state == tqlb_pkg::FSM_WRITE) upd_pend <= 1'b0;
      if (state == tqlb_pkg::FSM_OUT && slot_free) begin
        prev_state  <= cur_cls;
        last_action <= act_pick;
        have_prev   <= 1'b1;
      end
    end
  end

  // Item capture and working registers
  always_ff @(posedge clk) begin
    case (state)
      tqlb_pkg::FSM_IDLE: begin
        item_tilt  <= sample.tilt;
        item_rfrac <= sample.random_fraction;
        item_ract  <= sample.random_action;
      end
      tqlb_pkg::FSM_CLASS: begin
        cur_cls  <= cls_next;
        scan_j   <= '0;
        rew_val  <= tqlb_pkg::REW_NEUTRAL;
        upd_flag <= 1'b0;
      end
      tqlb_pkg::FSM_SCAN: begin
        // ties go to the later action
        if (scan_j == '0 || best_val <= q_rd) begin
          best_val <= q_rd;
          best_act <= scan_j;
        end
        scan_j <= scan_last ? '0 : scan_j + 1'b1;
      end
      tqlb_pkg::FSM_GMUL, tqlb_pkg::FSM_SMUL: prod <= prod_next;
      tqlb_pkg::FSM_DIFF: begin
        q_old   <= q_rd;
        diff    <= diff_next;
        rew_val <= rew_now;
      end
      tqlb_pkg::FSM_WRITE: begin
        upd_flag <= 1'b1;
        scan_j   <= '0;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == tqlb_pkg::FSM_OUT && slot_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == tqlb_pkg::FSM_OUT && slot_free) begin
      out_action  <= act_pick;
      out_cls     <= cur_cls;
      out_reward  <= rew_val;
      out_updated <= upd_flag;
    end
  end

  // Channel hookup
  assign sample.ready     = in_ready;
  assign cfg.ready        = 1'b1;
  assign result.valid     = out_valid;
  assign result.action    = out_action;
  assign result.cur_state = out_cls;
  assign result.reward    = out_reward;
  assign result.updated   = out_updated;

endmodule

@@ hdl/tqlb_checker.sv @@
// ----------------------------------------------------------------------------
// tqlb_checker
// Port-level checks on the balancer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tqlb_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [tqlb_pkg::ACT_W-1:0]         action,
  input logic [tqlb_pkg::CLS_W-1:0]         cur_state,
  input logic signed [tqlb_pkg::REW_W-1:0]  reward,
  input logic                               updated
);

  // One item at a time: no new beat right after one is taken
  `CHK_NEXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready)

  // Stalled result holds
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(action) && $stable(cur_state) && $stable(reward) && $stable(updated))

  // Action and class stay in range
  `CHK_IMPLIES(a_codes, clk, rst, out_valid, (action < tqlb_pkg::NUM_ACTIONS) && (cur_state != 2'd3))

  // No update means no reward reported
  `CHK_IMPLIES(a_rew_zero, clk, rst, out_valid && !updated, reward == '0)

endmodule

bind tabular_q_learning_balancer tqlb_checker u_tqlb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sample.valid),
  .in_ready  (sample.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .action    (result.action),
  .cur_state (result.cur_state),
  .reward    (result.reward),
  .updated   (result.updated)
);

@@ dv/tabular_q_learning_balancer_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tabular_q_learning_balancer_tb
// Self-checking bench for the Q-learning tilt balancer. Tilt samples go in
// over a valid/ready channel with random gaps. Each accepted beat runs through
// a local Q-table predictor, and the result channel, stalled at random, is
// checked field by field in order. Register settings change between phases
// while the block is idle. They cover the extremes of alpha, gamma, the
// balance band and epsilon.
// ----------------------------------------------------------------------------
module tabular_q_learning_balancer_tb;
  import tqlb_pkg::*;

  localparam int SETTLE_CYCLES  = 16;    // longer than the worst item latency plus return to idle
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int IDLE_PCT       = 14;
  localparam int TILT_LO        = -69120;
  localparam int TILT_HI        = 23040;

  typedef struct packed {
    logic signed [TILT_W-1:0] tilt;
    logic        [FRAC_W-1:0] rfrac;
    logic        [ACT_W-1:0]  ract;
  } sample_t;

  typedef struct packed {
    logic        [ACT_W-1:0] action;
    logic        [CLS_W-1:0] cls;
    logic signed [REW_W-1:0] reward;
    logic                    updated;
  } period_t;

  logic clk;
  logic rst;

  tqlb_in_if  sample_ch ();
  tqlb_out_if result_ch ();
  tqlb_cfg_if cfg_ch ();

  tabular_q_learning_balancer u_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // Stimulus and expectation stores
  sample_t pending_samples [$];
  period_t expected_periods [$];
  sample_t held;
  bit      steady;

  // Predictor state
  longint           q_val [NUM_STATES][Q_COLS];
  logic [CLS_W-1:0] m_prev_cls;
  logic [ACT_W-1:0] m_last_act;
  bit               m_have_prev;
  logic             m_train;
  logic [FRAC_W-1:0] m_alpha, m_gamma, m_band, m_epsilon;

  // Run statistics
  int n_periods, n_updates, n_explored, n_writes;
  int mismatches;
  int stall_cycles;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // floor((x * f + 2^15) / 2^16), exact
  function automatic longint scale_frac(input longint x, input logic [FRAC_W-1:0] f);
    return (x * longint'(f) + 32768) >>> 16;
  endfunction

  function automatic longint clamp_q(input longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (Q_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Argmax over the row, last index wins a tie
  function automatic logic [ACT_W-1:0] greedy_action(input logic [CLS_W-1:0] cls);
    int pick;
    pick = 0;
    for (int j = 0; j < NUM_ACTIONS; j++)
      if (q_val[cls][pick] <= q_val[cls][j]) pick = j;
    return ACT_W'(pick);
  endfunction

  function automatic longint period_reward(input logic [CLS_W-1:0] cur,
                                           input logic [CLS_W-1:0] prev);
    if (cur == CLS_LOW && prev == CLS_LOW) return longint'(REW_NEUTRAL);
    if (cur == CLS_HIGH && prev == CLS_HIGH) return longint'(REW_STUCK);
    if (cur == CLS_BAL) return (prev == CLS_BAL) ? longint'(REW_HOLD) : longint'(REW_GOAL);
    if (prev == CLS_BAL) return longint'(REW_FALL);
    return longint'(REW_NEUTRAL);
  endfunction

  function automatic void reset_predictor();
    for (int i = 0; i < NUM_STATES; i++)
      for (int j = 0; j < Q_COLS; j++)
        q_val[i][j] = clamp_q(longint'(Q_RESET[i * Q_COLS + j]));
    m_prev_cls  = CLS_BAL;
    m_last_act  = '0;
    m_have_prev = 1'b0;
    m_train     = 1'b0;
    m_alpha     = LRATE_RESET;
    m_gamma     = DISC_RESET;
    m_band      = BAND_RESET;
    m_epsilon   = EXPLORE_RESET;
  endfunction

  // One control period: classify, TD update, then choose the action
  function automatic period_t predict_period(input sample_t s);
    longint           t, mag, rew, q_old, g_term, diff;
    logic [CLS_W-1:0] cls, p;
    logic [ACT_W-1:0] a, act;
    period_t          r;
    t   = longint'($signed(s.tilt));
    mag = (t < 0) ? -t : t;
    if (mag < longint'(m_band) || t == 0) cls = CLS_BAL;
    else if (t > 0)                        cls = CLS_HIGH;
    else                                   cls = CLS_LOW;

    rew       = 0;
    r.updated = 1'b0;
    if (m_train && m_have_prev) begin
      p       = m_prev_cls;
      a       = m_last_act;
      q_old   = q_val[p][a];
      g_term  = scale_frac(q_val[cls][greedy_action(cls)], m_gamma);
      rew     = period_reward(cls, p);
      diff    = rew * 256 + g_term - q_old;
      q_val[p][a] = clamp_q(q_old + scale_frac(diff, m_alpha));
      r.updated = 1'b1;
    end

    // the row may just have changed, so the argmax is taken afterwards
    if (s.rfrac < m_epsilon) begin
      act = ACT_W'(int'(s.ract) % NUM_ACTIONS);
      n_explored++;
    end else begin
      act = greedy_action(cls);
    end

    m_last_act  = act;
    m_prev_cls  = cls;
    m_have_prev = 1'b1;

    r.action = act;
    r.cls    = cls;
    r.reward = REW_W'(rew);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Sample driver: one beat in flight, random gaps
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        expected_periods.push_back(predict_period(held));
        if (expected_periods[$].updated) n_updates++;
        n_periods++;
      end
      if (!sample_ch.valid || sample_ch.ready) begin
        if (pending_samples.size() != 0 &&
            (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          held = pending_samples.pop_front();
          sample_ch.valid           <= 1'b1;
          sample_ch.tilt            <= held.tilt;
          sample_ch.random_fraction <= held.rfrac;
          sample_ch.random_action   <= held.ract;
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor and random backpressure
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    period_t got, want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      if (result_ch.valid && result_ch.ready) begin
        got.action  = result_ch.action;
        got.cls     = result_ch.cur_state;
        got.reward  = result_ch.reward;
        got.updated = result_ch.updated;
        if (expected_periods.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result beat with nothing expected: act %0d cls %0d rew %0d upd %0b",
                     $realtime, got.action, got.cls, got.reward, got.updated);
        end else begin
          want = expected_periods.pop_front();
          if (got.action !== want.action || got.cls !== want.cls ||
              got.reward !== want.reward || got.updated !== want.updated) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: mismatch exp act %0d cls %0d rew %0d upd %0b, ",
                        "got act %0d cls %0d rew %0d upd %0b"},
                       $realtime, want.action, want.cls, want.reward, want.updated,
                       got.action, got.cls, got.reward, got.updated);
          end
        end
      end
    end
  end

  // Register model follows accepted write beats
  always @(posedge clk) begin
    if (!rst && cfg_ch.valid && cfg_ch.ready) begin
      n_writes++;
      case (cfg_ch.index)
        CFG_TRAIN:   m_train   = cfg_ch.data[0];
        CFG_LRATE:   m_alpha   = cfg_ch.data;
        CFG_DISC:    m_gamma   = cfg_ch.data;
        CFG_BAND:    m_band    = cfg_ch.data;
        CFG_EXPLORE: m_epsilon = cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Watchdog: cycles with no beat on any channel
  always @(posedge clk) begin
    if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               stall_cycles, expected_periods.size());
      $display("tabular_q_learning_balancer regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_item(input int t, input int rf, input int ra);
    sample_t s;
    s.tilt  = TILT_W'(t);
    s.rfrac = FRAC_W'(rf);
    s.ract  = ACT_W'(ra);
    pending_samples.push_back(s);
  endtask

  // Random fraction, biased toward the epsilon edge and the extremes
  function automatic int pick_fraction(input int eps);
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 65535;
      2:       return (eps > 0) ? eps - 1 : 0;
      3:       return eps;
      default: return int'($urandom_range(0, 65535));
    endcase
  endfunction

  // Mostly drifting tilt runs around the band, the rest isolated noise
  task automatic queue_random(input int count, input int band, input int eps);
    int left, len, pos, stride;
    left   = count;
    stride = band + 40;
    while (left > 0) begin
      if ($urandom_range(0, 9) < 7) begin
        len = $urandom_range(3, 10);
        if (len > left) len = left;
        pos = int'($urandom_range(0, 2 * stride)) - stride;
        repeat (len) begin
          queue_item(pos, pick_fraction(eps), $urandom_range(0, 3));
          pos += int'($urandom_range(0, 2 * stride)) - stride;
          if (pos < TILT_LO) pos = TILT_LO;
          if (pos > TILT_HI) pos = TILT_HI;
        end
        left -= len;
      end else begin
        case ($urandom_range(0, 2))
          0:       pos = int'($urandom);
          1:       pos = 0;
          default: pos = int'($urandom_range(0, TILT_HI - TILT_LO)) + TILT_LO;
        endcase
        queue_item(pos, pick_fraction(eps), $urandom_range(0, 3));
        left--;
      end
    end
  endtask

  // Wait until every beat is sent and every result has come back
  task automatic wait_drained();
    while (pending_samples.size() != 0 || sample_ch.valid || expected_periods.size() != 0)
      @(negedge clk);
  endtask

  // Call at a rising edge; leaves valid high for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= FRAC_W'(val);
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // Idle the block, load all registers, then run two halves with a full drain between
  task automatic run_phase(input int train, input int lr, input int disc, input int band,
                           input int eps, input int count, input bit no_gaps);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_TRAIN, train);
    write_reg(CFG_LRATE, lr);
    write_reg(CFG_DISC, disc);
    write_reg(CFG_BAND, band);
    write_reg(CFG_EXPLORE, eps);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
    steady = no_gaps;
    queue_random(count / 2, band, eps);
    wait_drained();
    queue_random(count - count / 2, band, eps);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    rst                       = 1'b1;
    steady                    = 1'b0;
    sample_ch.valid           = 1'b0;
    sample_ch.tilt            = '0;
    sample_ch.random_fraction = '0;
    sample_ch.random_action   = '0;
    result_ch.ready           = 1'b0;
    cfg_ch.valid              = 1'b0;
    cfg_ch.index              = CFG_TRAIN;
    cfg_ch.data               = '0;
    n_periods    = 0;
    n_updates    = 0;
    n_explored   = 0;
    n_writes     = 0;
    mismatches   = 0;
    stall_cycles = 0;
    reset_predictor();

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    repeat (3) @(posedge clk);

    // Default settings with training on: first period has no update, then
    // every reward pair, band edges and the tilt extremes
    write_reg(CFG_TRAIN, 1);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
    begin
      int directed_tilts [17];
      directed_tilts = '{0, 0, 26, 26, 0, -26, -26, 26, -26, 25, -25, 131071, -131072,
                         TILT_HI, TILT_LO, 1, -1};
      foreach (directed_tilts[k])
        queue_item(directed_tilts[k], $urandom_range(0, 65535), $urandom_range(0, 3));
    end

    // Zero band, full exploration, alpha and gamma at their maximum
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_BAND, 0);
    write_reg(CFG_EXPLORE, 65535);
    write_reg(CFG_LRATE, 65535);
    write_reg(CFG_DISC, 65535);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
    queue_item(0, 0, 0);            // zero tilt still balanced
    queue_item(1, 0, 1);
    queue_item(-1, 0, 2);
    queue_item(0, 0, 3);            // out-of-range random action wraps
    queue_item(5, 65534, 3);
    queue_item(-5, 65535, 1);       // fraction equal to epsilon: greedy
    queue_item(131071, 0, 2);
    queue_item(-131072, 65535, 0);

    // Random phases:      train lr     disc   band                eps    count quiet
    run_phase(1, int'(LRATE_RESET), int'(DISC_RESET), int'(BAND_RESET), 0, 60, 1'b1);
    run_phase(1, 65535, 65535, $urandom_range(0, 300), 16384, 70, 1'b0);
    run_phase(0, 0, 0, $urandom_range(0, 65535), 65535, 40, 1'b0);
    run_phase(1, 0, 0, 65535, 0, 50, 1'b0);
    run_phase(1, $urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(0, 2000), $urandom_range(0, 65535), 90, 1'b0);
    run_phase(1, 65535, 0, 0, 32768, 70, 1'b0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("checked %0d periods: %0d with a Q update, %0d explored, %0d register writes",
             n_periods, n_updates, n_explored, n_writes);
    $display("mismatches %0d, results outstanding %0d", mismatches, expected_periods.size());
    if (mismatches == 0 && expected_periods.size() == 0) begin
      $display("tabular_q_learning_balancer regression: pass");
    end else begin
      $display("tabular_q_learning_balancer regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/tqlb_pkg.sv
hdl/tqlb_if.sv
hdl/tabular_q_learning_balancer.sv
hdl/tqlb_checker.sv
dv/tabular_q_learning_balancer_tb.sv
